FILE: rtl/core/fully_associative_tlb_lru_top_macros.svh
// Assertion macros shared by the RTL that checks its own behavior.
`ifndef FULLY_ASSOCIATIVE_TLB_LRU_TOP_MACROS_SVH
`define FULLY_ASSOCIATIVE_TLB_LRU_TOP_MACROS_SVH

// Concurrent condition checked at every rising clock edge outside reset.
`define FATLB_ASSERT_HOLD(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("fatlb assertion failed");

// Condition that must hold in the cycle after a trigger.
`define FATLB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fatlb assertion failed");

`endif

FILE: rtl/core/fatlb_pkg.sv
package fatlb_pkg;

    localparam int DATA_W      = 32;
    localparam int SHIFT_W     = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = 5'd12;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic update;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
        logic out_block;
    } t_ctl_sts;

    typedef struct packed {
        logic [DATA_W-1:0] page;
        logic [DATA_W-1:0] frame;
        logic [DATA_W-1:0] stamp;
    } t_entry;

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

FILE: rtl/core/fatlb_ctrl.sv
module fatlb_ctrl import fatlb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_ready      = (r_state == ST_IDLE);
    assign o_cmd.start  = (r_state == ST_IDLE) && i_valid;
    assign o_cmd.update = (r_state == ST_UPD) && !i_sts.out_block;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.scan_last) n_state = ST_UPD;
            end
            ST_UPD: begin
                // The result register must be free before the entry is written.
                if (!i_sts.out_block) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/fatlb_datapath.sv
module fatlb_datapath import fatlb_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctl_cmd           i_cmd,
    output t_ctl_sts           o_sts,
    input  logic               i_cfg_valid,
    input  logic [SHIFT_W-1:0] i_cfg_data,
    input  logic [DATA_W-1:0]  i_virtual_address,
    input  logic [DATA_W-1:0]  i_miss_frame,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [DATA_W-1:0]  o_physical_address,
    output logic               o_hit,
    output logic [DATA_W-1:0]  o_hit_count,
    output logic [DATA_W-1:0]  o_miss_count
);

    localparam int IW = idx_width(ENTRIES);
    localparam int CW = IW + 1;

    logic [SHIFT_W-1:0] r_shift;
    logic [DATA_W-1:0]  r_page;
    logic [DATA_W-1:0]  r_offset;
    logic [DATA_W-1:0]  r_frame_in;

    t_entry             r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    logic [CW-1:0]      r_rd_idx;
    logic [IW-1:0]      r_cmp_idx;
    logic               r_cmp_en;
    logic               r_rd_vld;
    t_entry             r_rd_word;

    logic               r_found;
    logic [IW-1:0]      r_hit_idx;
    logic [DATA_W-1:0]  r_hit_frame;
    logic               r_inv_found;
    logic [IW-1:0]      r_inv_idx;
    logic [DATA_W-1:0]  r_min_stamp;
    logic [IW-1:0]      r_min_idx;

    logic [DATA_W-1:0]  r_stamp;
    logic [DATA_W-1:0]  r_hits;
    logic [DATA_W-1:0]  r_misses;

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_phys;
    logic               r_hit;

    logic [DATA_W-1:0]  n_stamp;
    logic [DATA_W-1:0]  n_hits;
    logic [DATA_W-1:0]  n_misses;
    logic               w_issue;
    logic [IW-1:0]      w_slot;
    logic [DATA_W-1:0]  w_frame;
    logic [DATA_W-1:0]  w_phys;

    assign w_issue  = (r_rd_idx < CW'(ENTRIES));
    assign n_stamp  = r_stamp + 32'd1;
    assign n_hits   = r_hits + {{(DATA_W-1){1'b0}}, r_found};
    assign n_misses = r_misses + {{(DATA_W-1){1'b0}}, !r_found};
    assign w_slot   = r_found ? r_hit_idx : (r_inv_found ? r_inv_idx : r_min_idx);
    assign w_frame  = r_found ? r_hit_frame : r_frame_in;
    assign w_phys   = (w_frame << r_shift) | r_offset;

    assign o_sts.scan_last = r_cmp_en && (r_cmp_idx == IW'(ENTRIES - 1));
    assign o_sts.out_block = r_out_valid && !i_ready;

    assign o_valid            = r_out_valid;
    assign o_physical_address = r_phys;
    assign o_hit              = r_hit;
    assign o_hit_count        = r_hits;
    assign o_miss_count       = r_misses;

    // Entry store: one write port for the update, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_mem[w_slot] <= '{page: r_page, frame: w_frame, stamp: n_stamp};
        end
        if (w_issue) begin
            r_rd_word <= r_mem[r_rd_idx[IW-1:0]];
        end
    end

    // Item capture, scan results and the result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_page     <= i_virtual_address >> r_shift;
            r_offset   <= i_virtual_address & ((32'd1 << r_shift) - 32'd1);
            r_frame_in <= i_miss_frame;
        end
        if (w_issue) begin
            r_rd_vld  <= r_valid[r_rd_idx[IW-1:0]];
            r_cmp_idx <= r_rd_idx[IW-1:0];
        end
        if (r_cmp_en) begin
            if (r_rd_vld && !r_found && (r_rd_word.page == r_page)) begin
                r_hit_idx   <= r_cmp_idx;
                r_hit_frame <= r_rd_word.frame;
            end
            if (!r_rd_vld && !r_inv_found) begin
                r_inv_idx <= r_cmp_idx;
            end
            // Strict compare keeps the lowest index on equal stamps.
            if ((r_cmp_idx == '0) || (r_rd_word.stamp < r_min_stamp)) begin
                r_min_stamp <= r_rd_word.stamp;
                r_min_idx   <= r_cmp_idx;
            end
        end
        if (i_cmd.update) begin
            r_phys <= w_phys;
            r_hit  <= r_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= PAGE_SHIFT_RESET;
            r_valid     <= '0;
            r_rd_idx    <= CW'(ENTRIES);
            r_cmp_en    <= 1'b0;
            r_found     <= 1'b0;
            r_inv_found <= 1'b0;
            r_stamp     <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_shift <= i_cfg_data;
            end
            if (i_cmd.start) begin
                r_rd_idx    <= '0;
                r_cmp_en    <= 1'b0;
                r_found     <= 1'b0;
                r_inv_found <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_rd_idx <= r_rd_idx + CW'(1);
                end
                r_cmp_en <= w_issue;
                if (r_cmp_en && r_rd_vld && (r_rd_word.page == r_page)) begin
                    r_found <= 1'b1;
                end
                if (r_cmp_en && !r_rd_vld) begin
                    r_inv_found <= 1'b1;
                end
            end
            if (i_cmd.update) begin
                r_valid[w_slot] <= 1'b1;
                r_stamp         <= n_stamp;
                r_hits          <= n_hits;
                r_misses        <= n_misses;
                r_out_valid     <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/core/fully_associative_tlb_lru_top.sv
// A result is registered in the update state, after the scan of all entries.
// New items wait until the last is done, paced by the scan of the entry store
// through its single read port, one entry per cycle.
// A pending result waits in the output register while the next item is scanned.
// Reset (synchronous, active low) clears all valid bits, the stamp, both counters
// and sets the page offset to 12 bits; no clearing pass is needed.
`include "fully_associative_tlb_lru_top_macros.svh"

module fully_associative_tlb_lru_top import fatlb_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SHIFT_W-1:0] i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [DATA_W-1:0]  i_virtual_address,
    input  logic [DATA_W-1:0]  i_miss_frame,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [DATA_W-1:0]  o_physical_address,
    output logic               o_hit,
    output logic [DATA_W-1:0]  o_hit_count,
    output logic [DATA_W-1:0]  o_miss_count
);

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    assign o_cfg_ready = 1'b1;

    fatlb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    fatlb_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_data         (i_cfg_data),
        .i_virtual_address  (i_virtual_address),
        .i_miss_frame       (i_miss_frame),
        .i_ready            (i_ready),
        .o_valid            (o_valid),
        .o_physical_address (o_physical_address),
        .o_hit              (o_hit),
        .o_hit_count        (o_hit_count),
        .o_miss_count       (o_miss_count)
    );

    `FATLB_ASSERT_NEXT(a_busy_after_transfer, i_valid && o_ready, !o_ready)
    `FATLB_ASSERT_NEXT(a_update_loads_result, w_cmd.update, o_valid)
    `FATLB_ASSERT_HOLD(a_no_result_overwrite, !(o_valid && !i_ready && w_cmd.update))
    `FATLB_ASSERT_HOLD(a_start_not_with_update, !(w_cmd.start && w_cmd.update))

endmodule
